FILE: hw/rtl/csrp_pkg.sv
// Shared types, constants and divider table for the clock synthesizer register planner.
package csrp_pkg;

    localparam int CRYSTAL_W = 26;
    localparam int FREQ_W    = 28;
    localparam logic [25:0] CRYSTAL_RESET = 26'd25000000;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] REG_PLLA_BASE  = 8'd26;
    localparam logic [7:0] REG_PLLB_BASE  = 8'd34;
    localparam logic [7:0] REG_MS0_BASE   = 8'd42;
    localparam logic [7:0] REG_MS1_BASE   = 8'd50;
    localparam logic [7:0] REG_CTRL0      = 8'd16;
    localparam logic [7:0] REG_CTRL1      = 8'd17;
    localparam logic [7:0] REG_PHASE0     = 8'd165;
    localparam logic [7:0] REG_PHASE1     = 8'd166;
    localparam logic [7:0] REG_PLL_RST    = 8'd177;
    localparam logic [7:0] CTRL_INT       = 8'h0f;
    localparam logic [7:0] CTRL_INT_PLLB  = 8'h2f;
    localparam logic [7:0] PLL_RST_BOTH   = 8'ha0;

    localparam logic [0:0] MODE_IQ    = 1'b0;
    localparam logic [0:0] MODE_INDEP = 1'b1;

    localparam logic [0:0] ADDR_CRYSTAL = 1'b0;

    localparam int QUAD_WRITES = 29;
    localparam int DUAL_WRITES = 34;

    typedef struct packed {
        logic              mode;
        logic [FREQ_W-1:0] freq_a;
        logic [FREQ_W-1:0] freq_b;
    } t_in;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       last_write;
    } t_out;

    // p1/p2 set for one PLL
    typedef struct packed {
        logic [31:0] p1;
        logic [19:0] p2;
    } t_pll_terms;

    function automatic logic [6:0] pick_divider(input logic [FREQ_W-1:0] f);
        logic [6:0] d;
        if      (f < 28'd6800000)   d = 7'd126;
        else if (f < 28'd8800000)   d = 7'd100;
        else if (f < 28'd12300000)  d = 7'd72;
        else if (f < 28'd17300000)  d = 7'd52;
        else if (f < 28'd24800000)  d = 7'd36;
        else if (f < 28'd32100000)  d = 7'd28;
        else if (f < 28'd44300000)  d = 7'd20;
        else if (f < 28'd56250000)  d = 7'd16;
        else if (f < 28'd75000000)  d = 7'd12;
        else if (f < 28'd112500000) d = 7'd8;
        else if (f < 28'd150000000) d = 7'd6;
        else                        d = 7'd4;
        return d;
    endfunction

endpackage

FILE: hw/rtl/clock_synth_register_planner.sv
// Top level: APB config, divider pick, two PLL term pipelines, write sequencer.
// Start is registered and passes the two PLL term pipelines (two 32/45-step pipelined
// dividers) before the first write strobe, then one write per cycle; 29 writes in
// quadrature, 34 in dual. A new transaction can start before the last is written;
// busy rises while QDEPTH transactions are outstanding. Results cannot be stalled.
// Reset (synchronous, active low) empties all pipelines and sets crystal to 25 MHz.
module clock_synth_register_planner #(
    parameter int QDEPTH = csrp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  csrp_pkg::t_in       i_item,
    output logic                o_strobe,
    output csrp_pkg::t_out      o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import csrp_pkg::*;

    localparam int PIPE = 1 + 33 + 46 + 1 + 1;
    // in flight count bounded so queue never overflows
    localparam int CW = $clog2(QDEPTH + PIPE + 2);

    logic [CRYSTAL_W-1:0] r_crystal;
    assign pready = 1'b1;
    assign prdata = (paddr[1] == ADDR_CRYSTAL) ? {6'd0, r_crystal} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_crystal <= CRYSTAL_RESET;
        else if (psel && penable && pwrite && paddr[1] == ADDR_CRYSTAL)
            r_crystal <= pwdata[CRYSTAL_W-1:0];
    end

    logic acc;
    assign acc = start && !busy;

    logic       r_v;
    logic       r_mode;
    logic [FREQ_W-1:0] r_fa, r_fb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else          r_v <= acc;
        r_mode <= i_item.mode;
        r_fa   <= i_item.freq_a;
        r_fb   <= i_item.freq_b;
    end

    logic [6:0] n_da, n_db;
    assign n_da = pick_divider(r_fa);
    assign n_db = pick_divider(r_fb);

    // side data delay matching the term pipelines
    logic [PIPE-2:0] r_sv;
    logic [14:0]     r_side [PIPE-1];
    always_ff @(posedge i_clk) begin
        r_side[0] <= {r_mode, n_da, n_db};
        for (int k = 1; k < PIPE - 1; k++) r_side[k] <= r_side[k-1];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else          r_sv <= {r_sv[PIPE-3:0], r_v};
    end

    logic va, vb;
    t_pll_terms ta, tb;
    csrp_terms u_terms_a (
        .i_clk, .i_rst_n, .i_valid(r_v), .i_freq(r_fa), .i_divr(n_da),
        .i_crystal(r_crystal), .o_valid(va), .o_terms(ta)
    );
    csrp_terms u_terms_b (
        .i_clk, .i_rst_n, .i_valid(r_v), .i_freq(r_fb), .i_divr(n_db),
        .i_crystal(r_crystal), .o_valid(vb), .o_terms(tb)
    );

    logic [14:0] side;
    assign side = r_side[PIPE-2];

    csrp_seq #(.DEPTH(QDEPTH)) u_seq (
        .i_clk, .i_rst_n, .i_valid(va & vb & r_sv[PIPE-2]),
        .i_mode(side[14]), .i_da(side[13:7]), .i_db(side[6:0]),
        .i_ta(ta), .i_tb(tb), .o_strobe, .o_out(o_result)
    );

    // outstanding transactions: accepted but last write not yet shown
    logic [CW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out <= '0;
        else r_out <= r_out + CW'(acc) - CW'(o_strobe && o_result.last_write);
    end
    assign busy = (r_out >= CW'(QDEPTH));
endmodule

FILE: hw/rtl/csrp_div.sv
// Pipelined restoring divider: one quotient bit per stage, valid travels with data.
module csrp_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 26,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem,
    output logic [TAG_W-1:0] o_tag
);
    logic [NUM_W:0]   r_vld;
    logic [NUM_W-1:0] r_num  [NUM_W+1];
    logic [DEN_W:0]   r_rem  [NUM_W+1];
    logic [DEN_W-1:0] r_den  [NUM_W+1];
    logic [TAG_W-1:0] r_tag  [NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[NUM_W-1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        r_rem[0] <= '0;
        r_den[0] <= i_den;
        r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W+1:0] n_trial;
        logic [DEN_W:0]   n_shift;
        assign n_shift = {r_rem[s][DEN_W-1:0], r_num[s][NUM_W-1]};
        assign n_trial = {1'b0, n_shift} - {2'b00, r_den[s]};
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            r_tag[s+1] <= r_tag[s];
            if (!n_trial[DEN_W+1]) begin
                r_rem[s+1] <= n_trial[DEN_W:0];
                r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_shift;
                r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_rem   = r_rem[NUM_W][DEN_W-1:0];
    assign o_tag   = r_tag[NUM_W];
endmodule

FILE: hw/rtl/csrp_terms.sv
// Per-PLL feedback term pipeline: pll freq, a/b division, p1/p2 packing terms.
module csrp_terms (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [csrp_pkg::FREQ_W-1:0] i_freq,
    input  logic [6:0]                i_divr,
    input  logic [csrp_pkg::CRYSTAL_W-1:0] i_crystal,
    output logic                      o_valid,
    output csrp_pkg::t_pll_terms      o_terms
);
    import csrp_pkg::*;

    logic        r_v0;
    logic [31:0] r_fpll;
    logic [CRYSTAL_W-1:0] r_xtal0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_valid;
        r_fpll  <= 32'({4'd0, i_freq} * {25'd0, i_divr});
        r_xtal0 <= i_crystal;
    end

    // first division: fpll / crystal
    logic                 d1_v;
    logic [31:0]          d1_q;
    logic [CRYSTAL_W-1:0] d1_r;
    logic [CRYSTAL_W-1:0] d1_x;

    csrp_div #(.NUM_W(32), .DEN_W(CRYSTAL_W), .TAG_W(CRYSTAL_W)) u_div_a (
        .i_clk, .i_rst_n,
        .i_valid(r_v0), .i_num(r_fpll), .i_den(r_xtal0), .i_tag(r_xtal0),
        .o_valid(d1_v), .o_quot(d1_q), .o_rem(d1_r), .o_tag(d1_x)
    );

    // second division: rem * 2^19 / crystal; remainder < crystal < 2^26 so 45 bits
    localparam int BN_W = CRYSTAL_W + 19;
    logic          d2_v;
    logic [BN_W-1:0] d2_q;
    logic [CRYSTAL_W-1:0] d2_rem_unused;
    logic [8:0]    d2_tag;
    logic [7:0]    d2_a;
    logic          d2_z;
    logic          zero_x;

    assign zero_x = (d1_x == '0);

    csrp_div #(.NUM_W(BN_W), .DEN_W(CRYSTAL_W), .TAG_W(9)) u_div_b (
        .i_clk, .i_rst_n,
        .i_valid(d1_v), .i_num({d1_r, 19'd0}), .i_den(d1_x),
        .i_tag({zero_x, zero_x ? 8'hff : d1_q[7:0]}),
        .o_valid(d2_v), .o_quot(d2_q), .o_rem(d2_rem_unused), .o_tag(d2_tag)
    );

    assign d2_a = d2_tag[7:0];
    assign d2_z = d2_tag[8];

    // zero crystal: divider output is meaningless, b is forced to 0
    logic [31:0] n_b;
    logic [31:0] n_q;
    logic [31:0] n_b128;
    assign n_b    = d2_z ? 32'd0 : d2_q[31:0];
    assign n_b128 = {n_b[24:0], 7'd0};
    assign n_q    = {19'd0, n_b128[31:19]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= d2_v;
        o_terms.p1 <= {17'd0, d2_a, 7'd0} + n_q - 32'd512;
        o_terms.p2 <= {1'b0, n_b128[18:0]};
    end
endmodule

FILE: hw/rtl/csrp_seq.sv
// Write sequencer: queues planned items and emits one register write per cycle.
module csrp_seq #(
    parameter int DEPTH = csrp_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_mode,
    input  logic [6:0]           i_da,
    input  logic [6:0]           i_db,
    input  csrp_pkg::t_pll_terms i_ta,
    input  csrp_pkg::t_pll_terms i_tb,
    output logic                 o_strobe,
    output csrp_pkg::t_out       o_out
);
    import csrp_pkg::*;
    localparam int AW = $clog2(DEPTH);

    typedef struct packed {
        logic       mode;
        logic [6:0] da;
        logic [6:0] db;
        t_pll_terms ta;
        t_pll_terms tb;
    } t_job;

    t_job         r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]  r_cnt;
    logic [5:0]   r_idx;
    logic         n_pop;
    t_job         cur;
    logic [5:0]   n_total;

    assign cur     = r_q[r_rp];
    assign n_total = cur.mode ? 6'(DUAL_WRITES - 1) : 6'(QUAD_WRITES - 1);
    assign n_pop   = (r_cnt != '0) && (r_idx == n_total);

    always_ff @(posedge i_clk) begin
        if (i_valid) r_q[r_wp] <= '{mode: i_mode, da: i_da, db: i_db, ta: i_ta, tb: i_tb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_idx <= '0;
        end else begin
            if (i_valid) r_wp <= AW'(r_wp + 1'b1);
            if (n_pop)   r_rp <= AW'(r_rp + 1'b1);
            r_cnt <= r_cnt + (AW+1)'(i_valid) - (AW+1)'(n_pop);
            if (n_pop)              r_idx <= '0;
            else if (r_cnt != '0)   r_idx <= r_idx + 6'd1;
        end
    end

    function automatic logic [7:0] pll_byte(input t_pll_terms t, input logic [2:0] k);
        logic [7:0] v;
        case (k)
            3'd0: v = 8'h00;
            3'd1: v = 8'h00;
            3'd2: v = t.p1[23:16];
            3'd3: v = t.p1[15:8];
            3'd4: v = t.p1[7:0];
            3'd5: v = {4'h0, t.p2[19:16]};
            3'd6: v = t.p2[15:8];
            default: v = t.p2[7:0];
        endcase
        // denominator 0x80000 gives bytes 0x00, 0x00 and high nibble 0x8
        if (k == 3'd5) v[7:4] = 4'h8;
        return v;
    endfunction

    function automatic logic [7:0] ms_byte(input logic [6:0] d, input logic [2:0] k);
        logic [31:0] p1;
        logic [7:0]  v;
        p1 = {18'd0, d, 7'd0} - 32'd512;
        case (k)
            3'd1: v = 8'd1;
            3'd2: v = p1[23:16];
            3'd3: v = p1[15:8];
            3'd4: v = p1[7:0];
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    logic [7:0] n_addr, n_data;
    logic [5:0] j;
    always_comb begin
        n_addr = '0;
        n_data = '0;
        j = r_idx;
        if (j < 6'd8) begin
            n_addr = REG_PLLA_BASE + 8'(j);
            n_data = pll_byte(cur.ta, j[2:0]);
        end else if (cur.mode == MODE_INDEP) begin
            if (j < 6'd16) begin
                n_addr = REG_PLLB_BASE + 8'(j - 6'd8);
                n_data = pll_byte(cur.tb, j[2:0]);
            end else if (j < 6'd24) begin
                n_addr = REG_MS0_BASE + 8'(j - 6'd16);
                n_data = ms_byte(cur.da, j[2:0]);
            end else if (j == 6'd24) begin
                n_addr = REG_CTRL0; n_data = CTRL_INT;
            end else if (j < 6'd33) begin
                n_addr = REG_MS1_BASE + 8'(j - 6'd25);
                n_data = ms_byte(cur.db, 3'(j - 6'd25));
            end else begin
                n_addr = REG_CTRL1; n_data = CTRL_INT_PLLB;
            end
        end else begin
            if (j < 6'd16) begin
                n_addr = REG_MS0_BASE + 8'(j - 6'd8);
                n_data = ms_byte(cur.da, j[2:0]);
            end else if (j == 6'd16) begin
                n_addr = REG_CTRL0; n_data = CTRL_INT;
            end else if (j < 6'd25) begin
                n_addr = REG_MS1_BASE + 8'(j - 6'd17);
                n_data = ms_byte(cur.da, 3'(j - 6'd17));
            end else if (j == 6'd25) begin
                n_addr = REG_CTRL1; n_data = CTRL_INT;
            end else if (j == 6'd26) begin
                n_addr = REG_PHASE0; n_data = 8'd0;
            end else if (j == 6'd27) begin
                n_addr = REG_PHASE1; n_data = {1'b0, cur.da};
            end else begin
                n_addr = REG_PLL_RST; n_data = PLL_RST_BOTH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else          o_strobe <= (r_cnt != '0);
        o_out.reg_address <= n_addr;
        o_out.reg_data    <= n_data;
        o_out.last_write  <= n_pop;
    end
endmodule
